// ===== design/ljpf_pkg.sv =====
// ljpf_pkg: widths, register indexes and constants shared by the pair force pipeline
// used by ljpf_mul, lennard_jones_pair_force and ljpf_chk; no dependencies
`default_nettype none

package ljpf_pkg;

    localparam int IN_W      = 24;
    localparam int OUT_W     = 48;
    localparam int CFG_IDX_W = 2;
    localparam int OPD_W     = 64;
    localparam int RES_W     = 62;
    localparam int MUL_LAT   = 4;
    localparam int DIV2_STEPS = 48;

    localparam logic [CFG_IDX_W-1:0] REG_WELL_DEPTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_DISTANCE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CUTOFF_RADIUS = 2'd2;

    localparam logic [OPD_W-1:0] BIG_CAP  = 64'h3FFF_FFFF_FFFF_FFFF;
    localparam logic [OPD_W-1:0] GRAD_CAP = BIG_CAP / 24;
    localparam logic [OPD_W-1:0] POS_MAX  = 64'h0000_7FFF_FFFF_FFFF;
    localparam logic [OPD_W-1:0] NEG_MAG  = 64'h0000_8000_0000_0000;

    localparam logic [OUT_W-1:0] OUT_POS = 48'h7FFF_FFFF_FFFF;
    localparam logic [OUT_W-1:0] OUT_NEG = 48'h8000_0000_0000;

endpackage

`default_nettype wire

// ===== design/ljpf_mul.sv =====
// ljpf_mul: four-stage 64x64 fixed point multiplier, result floor(a*b / 2^FRAC_BITS)
// flags products at or above 2^(62+FRAC_BITS); uses ljpf_pkg
`default_nettype none

module ljpf_mul #(
    parameter int FRAC_BITS = 16
) (
    input  logic                         i_clk,
    input  logic [ljpf_pkg::OPD_W-1:0]   i_a,
    input  logic [ljpf_pkg::OPD_W-1:0]   i_b,
    output logic [ljpf_pkg::RES_W-1:0]   o_res,
    output logic                         o_huge
);

    localparam int HALF = ljpf_pkg::OPD_W / 2;
    localparam int PW   = 2 * ljpf_pkg::OPD_W;
    localparam int TOP  = FRAC_BITS + ljpf_pkg::RES_W;

    logic [ljpf_pkg::OPD_W-1:0] r_p0, r_p1, r_p2, r_p3;
    logic [ljpf_pkg::OPD_W-1:0] r_lo, r_hi;
    logic [ljpf_pkg::OPD_W:0]   r_mid;
    logic [PW-1:0]              r_full;
    logic [ljpf_pkg::RES_W-1:0] r_res;
    logic                       r_huge;

    // partial products
    always_ff @(posedge i_clk) begin
        r_p0 <= i_a[HALF-1:0] * i_b[HALF-1:0];
        r_p1 <= i_a[2*HALF-1:HALF] * i_b[HALF-1:0];
        r_p2 <= i_a[HALF-1:0] * i_b[2*HALF-1:HALF];
        r_p3 <= i_a[2*HALF-1:HALF] * i_b[2*HALF-1:HALF];
    end

    always_ff @(posedge i_clk) begin
        r_lo  <= r_p0;
        r_hi  <= r_p3;
        r_mid <= {1'b0, r_p1} + {1'b0, r_p2};
    end

    always_ff @(posedge i_clk) begin
        r_full <= {r_hi, r_lo} + (PW'(r_mid) << HALF);
    end

    always_ff @(posedge i_clk) begin
        r_res  <= r_full[TOP-1:FRAC_BITS];
        r_huge <= |r_full[PW-1:TOP];
    end

    assign o_res  = r_res;
    assign o_huge = r_huge;

endmodule

`default_nettype wire

// ===== design/lennard_jones_pair_force.sv =====
// lennard_jones_pair_force: pipelined 12-6 pair potential and radial derivative
// instantiates ljpf_mul; uses ljpf_pkg
//
// channel   ports                                          handshake
// command   i_start, i_distance                            taken when i_start and not o_busy
// config    i_cfg_we, i_cfg_idx, i_cfg_data                written on any edge with i_cfg_we out of reset
// result    o_done, o_energy, o_gradient, o_saturated      o_done high for one cycle per word
//
// one word enters per clock while o_busy is low; from the accepting edge o_done follows through
// the radix-2 divider chains (24 + FRAC_BITS and 48 steps), five passes through four-stage
// multipliers and single register stages at the input, at stages d, g and h and at the output
// o_busy is high during reset and clears at the first edge after release; reset drops every word in flight
// the result side cannot stall, so nothing ever holds the pipeline
`default_nettype none

module lennard_jones_pair_force #(
    parameter int FRAC_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [ljpf_pkg::IN_W-1:0]         i_distance,
    input  logic                              i_cfg_we,
    input  logic [ljpf_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [ljpf_pkg::IN_W-1:0]         i_cfg_data,
    output logic                              o_busy,
    output logic                              o_done,
    output logic [ljpf_pkg::OUT_W-1:0]        o_energy,
    output logic [ljpf_pkg::OUT_W-1:0]        o_gradient,
    output logic                              o_saturated
);

    localparam int IW  = ljpf_pkg::IN_W;
    localparam int OW  = ljpf_pkg::OPD_W;
    localparam int RW  = ljpf_pkg::RES_W;
    localparam int EW  = ljpf_pkg::OUT_W;
    localparam int ML  = ljpf_pkg::MUL_LAT;
    localparam int Q2  = ljpf_pkg::DIV2_STEPS;
    localparam int QW1 = IW + FRAC_BITS;

    localparam logic [IW-1:0] ONE_RESET = IW'(64'd1 << FRAC_BITS);
    localparam logic [IW-1:0] CUT_RESET = IW'(64'd5 << (FRAC_BITS - 1));

    typedef enum logic [1:0] {K_NORMAL, K_BEYOND, K_ZERO_R, K_ZERO_EPS} t_kind;

    typedef struct packed {
        t_kind         kind;
        logic          huge;
        logic [IW-1:0] r;
    } t_tag;

    typedef struct packed {
        t_tag          tag;
        logic [OW-1:0] aux;
    } t_side;

    typedef struct packed {
        t_tag          tag;
        logic [EW-1:0] ecode;
        logic          esat;
        logic          gneg;
        logic          ovf;
    } t_d2;

    // configuration
    logic [IW-1:0] r_well_depth, r_zero_distance, r_cutoff_radius;
    logic          r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_well_depth    <= ONE_RESET;
            r_zero_distance <= ONE_RESET;
            r_cutoff_radius <= CUT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ljpf_pkg::REG_WELL_DEPTH:    r_well_depth    <= i_cfg_data;
                ljpf_pkg::REG_ZERO_DISTANCE: r_zero_distance <= i_cfg_data;
                ljpf_pkg::REG_CUTOFF_RADIUS: r_cutoff_radius <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign o_busy = r_busy;

    // input word classification
    logic n_accept;
    t_tag n_in_tag;

    assign n_accept = i_start && !r_busy;

    always_comb begin
        n_in_tag.r    = i_distance;
        n_in_tag.huge = 1'b0;
        if (i_distance > r_cutoff_radius) begin
            n_in_tag.kind = K_BEYOND;
        end else if (i_distance == '0) begin
            n_in_tag.kind = K_ZERO_R;
        end else if (r_well_depth == '0) begin
            n_in_tag.kind = K_ZERO_EPS;
        end else begin
            n_in_tag.kind = K_NORMAL;
        end
    end

    // divider one: q = sigma * 2^F / r, one quotient bit per stage
    logic           r_v1   [QW1+1];
    t_tag           r_t1   [QW1+1];
    logic [IW-1:0]  r_rem1 [QW1+1];
    logic [QW1-1:0] r_wrk1 [QW1+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1[0] <= 1'b0;
        end else begin
            r_v1[0] <= n_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t1[0]   <= n_in_tag;
        r_rem1[0] <= '0;
        r_wrk1[0] <= {r_zero_distance, {FRAC_BITS{1'b0}}};
    end

    for (genvar k = 0; k < QW1; k++) begin : g_div1
        logic [IW:0] trial;
        logic        ge;

        assign trial = {r_rem1[k], r_wrk1[k][QW1-1]};
        assign ge    = trial >= {1'b0, r_t1[k].r};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v1[k+1] <= 1'b0;
            end else begin
                r_v1[k+1] <= r_v1[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_t1[k+1]   <= r_t1[k];
            r_rem1[k+1] <= ge ? IW'(trial - {1'b0, r_t1[k].r}) : trial[IW-1:0];
            r_wrk1[k+1] <= {r_wrk1[k][QW1-2:0], ge};
        end
    end

    // multipliers with side delay lines
    // 0: q*q  1: s2*q  2: s3*s3  3: s6*s6  4/5: eps*|s12-s6|, eps*|s6-2*s12|
    logic          mv_in [5];
    t_side         ms_in [5];
    logic          r_mv  [5][ML];
    t_side         r_ms  [5][ML];
    logic [OW-1:0] ma    [6];
    logic [OW-1:0] mb    [6];
    logic [RW-1:0] mr    [6];
    logic          mh    [6];

    for (genvar j = 0; j < 5; j++) begin : g_dly
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_mv[j][0] <= 1'b0;
            end else begin
                r_mv[j][0] <= mv_in[j];
            end
        end

        always_ff @(posedge i_clk) begin
            r_ms[j][0] <= ms_in[j];
        end

        for (genvar k = 1; k < ML; k++) begin : g_tap
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_mv[j][k] <= 1'b0;
                end else begin
                    r_mv[j][k] <= r_mv[j][k-1];
                end
            end

            always_ff @(posedge i_clk) begin
                r_ms[j][k] <= r_ms[j][k-1];
            end
        end
    end

    for (genvar j = 0; j < 6; j++) begin : g_mul
        ljpf_mul #(
            .FRAC_BITS (FRAC_BITS)
        ) u_mul (
            .i_clk  (i_clk),
            .i_a    (ma[j]),
            .i_b    (mb[j]),
            .o_res  (mr[j]),
            .o_huge (mh[j])
        );
    end

    // stage d: differences of the powers
    logic          r_d_vld;
    t_tag          r_d_tag;
    logic          r_d_eneg, r_d_gneg;
    logic [OW-1:0] r_d_de, r_d_dg;

    t_tag          n_d_tag;
    logic [OW-1:0] n_s12, n_s6, n_two12;
    logic          n_eneg, n_gneg;

    assign n_s12   = OW'(mr[3]);
    assign n_s6    = r_ms[3][ML-1].aux;
    assign n_two12 = n_s12 << 1;
    assign n_eneg  = n_s12 < n_s6;
    assign n_gneg  = n_two12 > n_s6;

    always_comb begin
        n_d_tag      = r_ms[3][ML-1].tag;
        n_d_tag.huge = r_ms[3][ML-1].tag.huge | mh[3];
    end

    always_comb begin
        mv_in[0]     = r_v1[QW1];
        ms_in[0].tag = r_t1[QW1];
        ms_in[0].aux = OW'(r_wrk1[QW1]);
        ma[0]        = OW'(r_wrk1[QW1]);
        mb[0]        = OW'(r_wrk1[QW1]);

        mv_in[1]          = r_mv[0][ML-1];
        ms_in[1]          = r_ms[0][ML-1];
        ms_in[1].tag.huge = r_ms[0][ML-1].tag.huge | mh[0];
        ma[1]             = OW'(mr[0]);
        mb[1]             = r_ms[0][ML-1].aux;

        mv_in[2]          = r_mv[1][ML-1];
        ms_in[2]          = r_ms[1][ML-1];
        ms_in[2].tag.huge = r_ms[1][ML-1].tag.huge | mh[1];
        ma[2]             = OW'(mr[1]);
        mb[2]             = OW'(mr[1]);

        mv_in[3]          = r_mv[2][ML-1];
        ms_in[3]          = r_ms[2][ML-1];
        ms_in[3].tag.huge = r_ms[2][ML-1].tag.huge | mh[2];
        ms_in[3].aux      = OW'(mr[2]);
        ma[3]             = OW'(mr[2]);
        mb[3]             = OW'(mr[2]);

        mv_in[4]     = r_d_vld;
        ms_in[4].tag = r_d_tag;
        ms_in[4].aux = OW'({r_d_gneg, r_d_eneg});
        ma[4]        = OW'(r_well_depth);
        mb[4]        = r_d_de;
        ma[5]        = OW'(r_well_depth);
        mb[5]        = r_d_dg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else begin
            r_d_vld <= r_mv[3][ML-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_d_tag  <= n_d_tag;
        r_d_eneg <= n_eneg;
        r_d_gneg <= n_gneg;
        r_d_de   <= n_eneg ? n_s6 - n_s12 : n_s12 - n_s6;
        r_d_dg   <= n_gneg ? n_two12 - n_s6 : n_s6 - n_two12;
    end

    // stage g: energy magnitude and capped 24*g
    logic          r_g_vld;
    t_tag          r_g_tag;
    logic [OW-1:0] r_g_emag;
    logic          r_g_ehuge, r_g_eneg, r_g_gneg;
    logic [RW-1:0] r_g_gc;

    logic [RW-1:0] n_g24;
    logic          n_gcap;

    assign n_g24  = RW'({mr[5], 4'b0000} + {1'b0, mr[5], 3'b000});
    assign n_gcap = mh[5] || (OW'(mr[5]) > ljpf_pkg::GRAD_CAP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_vld <= 1'b0;
        end else begin
            r_g_vld <= r_mv[4][ML-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_g_tag   <= r_ms[4][ML-1].tag;
        r_g_emag  <= {mr[4], 2'b00};
        r_g_ehuge <= mh[4];
        r_g_eneg  <= r_ms[4][ML-1].aux[0];
        r_g_gneg  <= r_ms[4][ML-1].aux[1];
        r_g_gc    <= n_gcap ? RW'(ljpf_pkg::BIG_CAP) : n_g24;
    end

    // stage h: energy word, divider two setup
    logic [RW+FRAC_BITS-1:0] n_gsh;
    logic                    n_ovf, n_esat;
    logic [OW-1:0]           n_elim;
    logic [EW-1:0]           n_ecode;
    t_d2                     n_p2;

    assign n_gsh  = {r_g_gc, {FRAC_BITS{1'b0}}};
    assign n_ovf  = OW'(r_g_gc) >= (OW'(r_g_tag.r) << (Q2 - FRAC_BITS));
    assign n_elim = r_g_eneg ? ljpf_pkg::NEG_MAG : ljpf_pkg::POS_MAX;
    assign n_esat = r_g_ehuge || (r_g_emag > n_elim);

    always_comb begin
        if (n_esat) begin
            n_ecode = r_g_eneg ? ljpf_pkg::OUT_NEG : ljpf_pkg::OUT_POS;
        end else if (r_g_eneg) begin
            n_ecode = {EW{1'b0}} - r_g_emag[EW-1:0];
        end else begin
            n_ecode = r_g_emag[EW-1:0];
        end
        n_p2.tag   = r_g_tag;
        n_p2.ecode = n_ecode;
        n_p2.esat  = n_esat;
        n_p2.gneg  = r_g_gneg;
        n_p2.ovf   = n_ovf;
    end

    // divider two: gradient = 24*g * 2^F / r, 48 quotient bits
    logic          r_v2   [Q2+1];
    t_d2           r_p2   [Q2+1];
    logic [IW-1:0] r_rem2 [Q2+1];
    logic [Q2-1:0] r_wrk2 [Q2+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2[0] <= 1'b0;
        end else begin
            r_v2[0] <= r_g_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p2[0]   <= n_p2;
        r_rem2[0] <= IW'(n_gsh >> Q2);
        r_wrk2[0] <= n_gsh[Q2-1:0];
    end

    for (genvar k = 0; k < Q2; k++) begin : g_div2
        logic [IW:0] trial;
        logic        ge;

        assign trial = {r_rem2[k], r_wrk2[k][Q2-1]};
        assign ge    = trial >= {1'b0, r_p2[k].tag.r};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v2[k+1] <= 1'b0;
            end else begin
                r_v2[k+1] <= r_v2[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_p2[k+1]   <= r_p2[k];
            r_rem2[k+1] <= ge ? IW'(trial - {1'b0, r_p2[k].tag.r}) : trial[IW-1:0];
            r_wrk2[k+1] <= {r_wrk2[k][Q2-2:0], ge};
        end
    end

    // output stage
    t_d2           n_fin;
    logic [EW-1:0] n_quo, n_gcode, n_energy, n_gradient;
    logic          n_gsat, n_sat;

    assign n_fin = r_p2[Q2];
    assign n_quo = r_wrk2[Q2];
    assign n_gsat = n_fin.ovf || (n_fin.gneg ? (n_quo > ljpf_pkg::OUT_NEG)
                                             : (n_quo > ljpf_pkg::OUT_POS));

    always_comb begin
        if (n_gsat) begin
            n_gcode = n_fin.gneg ? ljpf_pkg::OUT_NEG : ljpf_pkg::OUT_POS;
        end else if (n_fin.gneg) begin
            n_gcode = {EW{1'b0}} - n_quo;
        end else begin
            n_gcode = n_quo;
        end

        unique case (n_fin.tag.kind) inside
            K_BEYOND, K_ZERO_EPS: begin
                n_energy   = '0;
                n_gradient = '0;
                n_sat      = 1'b0;
            end
            K_ZERO_R: begin
                n_energy   = ljpf_pkg::OUT_POS;
                n_gradient = ljpf_pkg::OUT_NEG;
                n_sat      = 1'b1;
            end
            default: begin
                if (n_fin.tag.huge) begin
                    n_energy   = ljpf_pkg::OUT_POS;
                    n_gradient = ljpf_pkg::OUT_NEG;
                    n_sat      = 1'b1;
                end else begin
                    n_energy   = n_fin.ecode;
                    n_gradient = n_gcode;
                    n_sat      = n_fin.esat | n_gsat;
                end
            end
        endcase
    end

    logic          r_done;
    logic [EW-1:0] r_energy, r_gradient;
    logic          r_saturated;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_v2[Q2];
        end
    end

    always_ff @(posedge i_clk) begin
        r_energy    <= n_energy;
        r_gradient  <= n_gradient;
        r_saturated <= n_sat;
    end

    assign o_done      = r_done;
    assign o_energy    = r_energy;
    assign o_gradient  = r_gradient;
    assign o_saturated = r_saturated;

endmodule

`default_nettype wire

// ===== design/ljpf_chk.sv =====
// ljpf_chk: port-level checks for lennard_jones_pair_force
// bound to the top level below; uses ljpf_pkg
`default_nettype none

module ljpf_chk #(
    parameter int FRAC_BITS = 16
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_start,
    input logic                        o_busy,
    input logic                        o_done,
    input logic [ljpf_pkg::OUT_W-1:0]  o_energy,
    input logic                        o_saturated
);

    localparam int LAT = ljpf_pkg::IN_W + FRAC_BITS + 73;

    logic accept;

    assign accept = i_rst_n && i_start && !o_busy;

    a_done_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_done)
        else $error("result word right after reset");

    a_busy_run: assert property (@(posedge i_clk) i_rst_n && $past(i_rst_n) |-> !o_busy)
        else $error("busy outside reset recovery");

    a_lat_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##LAT o_done)
        else $error("accepted word produced no result");

    a_lat_bwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(accept, LAT))
        else $error("result word without matching command");

    a_energy_q: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_saturated |-> o_energy[1:0] == 2'b00)
        else $error("unclipped energy not a multiple of four");

endmodule

bind lennard_jones_pair_force ljpf_chk #(.FRAC_BITS(FRAC_BITS)) u_ljpf_chk (.*);

`default_nettype wire
